// ----- hdl/fsct_pkg.sv -----
`timescale 1ns / 1ps
package fsct_pkg;
    localparam int COORD_WIDTH_DEF = 20;
    localparam int AXIS_WIDTH_DEF  = 16;
    localparam int HALF_WIDTH      = 19;
    localparam int DIST_WIDTH      = 19;
    localparam int SLOPE_WIDTH     = 16;
    localparam int FLAG_WIDTH      = 3;
    localparam int VERDICT_WIDTH   = 2;
    localparam int SQ_WIDTH        = 2 * HALF_WIDTH + 2;
    localparam int RAD_WIDTH       = SQ_WIDTH / 2;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_CAMERA  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FORWARD = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UP      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RIGHT   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_NEAR    = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FAR     = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SLOPE_H = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SLOPE_V = 3'd7;

    localparam logic [VERDICT_WIDTH-1:0] VERDICT_DISJOINT  = 2'd0;
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_CONTAIN   = 2'd2;

    localparam logic [SLOPE_WIDTH-1:0] SLOPE_RESET = 16'd4096;

    // per-axis outcome
    localparam logic [1:0] AX_FAIL    = 2'd0;
    localparam logic [1:0] AX_PARTIAL = 2'd1;
    localparam logic [1:0] AX_INSIDE  = 2'd2;
endpackage

// ----- hdl/frustum_sphere_cull_test.sv -----
`timescale 1ns / 1ps
// Frustum cull of a box bounded by a sphere. One box per clock is accepted while the
// output is not stalled, and each gives one verdict. The square root has NSQ =
// RAD_WIDTH stages, 20 by default, one result bit per stage, and sets the depth of
// the pipeline; it takes the root of the half-extent length.
// The pipeline stalls as a whole when the output holds a verdict and m_axis_tready is low.
// Configuration must be written only while the pipeline is empty.
module frustum_sphere_cull_test #(
    parameter int COORD_WIDTH = fsct_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_WIDTH  = fsct_pkg::AXIS_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [fsct_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [fsct_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, zero fill
    input  logic [((3*COORD_WIDTH+3*fsct_pkg::HALF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // flags_in
    input  logic [fsct_pkg::FLAG_WIDTH-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // verdict, flags_out, zero fill
    output logic [7:0] m_axis_tdata
);
    localparam int CW = COORD_WIDTH;
    localparam int AW = AXIS_WIDTH;
    localparam int HW = fsct_pkg::HALF_WIDTH;
    localparam int OW = CW + 1;            // offset
    localparam int PW = OW + AW;           // product
    localparam int SW = PW + 2;            // dot sum
    localparam int JW = SW - (AW - 2);     // projection
    localparam int RW = fsct_pkg::RAD_WIDTH;
    localparam int QW = fsct_pkg::SQ_WIDTH;
    localparam int LW = JW + fsct_pkg::SLOPE_WIDTH + 2; // lateral Q.20 compare width
    localparam int NSQ = RW;
    localparam int DEPTH = NSQ + 6;
    localparam int INW = ((3*CW+3*HW+7)/8)*8;

    // configuration registers
    logic [3*CW-1:0] r_cam;
    logic [3*AW-1:0] r_fwd, r_up, r_rgt;
    logic [fsct_pkg::DIST_WIDTH-1:0] r_near, r_far;
    logic [fsct_pkg::SLOPE_WIDTH-1:0] r_sh, r_sv;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam <= '0; r_fwd <= '0; r_up <= '0; r_rgt <= '0;
            r_near <= '0; r_far <= '0;
            r_sh <= fsct_pkg::SLOPE_RESET; r_sv <= fsct_pkg::SLOPE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fsct_pkg::REG_CAMERA:  r_cam  <= i_cfg_data[3*CW-1:0];
                fsct_pkg::REG_FORWARD: r_fwd  <= i_cfg_data[3*AW-1:0];
                fsct_pkg::REG_UP:      r_up   <= i_cfg_data[3*AW-1:0];
                fsct_pkg::REG_RIGHT:   r_rgt  <= i_cfg_data[3*AW-1:0];
                fsct_pkg::REG_NEAR:    r_near <= i_cfg_data[fsct_pkg::DIST_WIDTH-1:0];
                fsct_pkg::REG_FAR:     r_far  <= i_cfg_data[fsct_pkg::DIST_WIDTH-1:0];
                fsct_pkg::REG_SLOPE_H: r_sh   <= i_cfg_data[fsct_pkg::SLOPE_WIDTH-1:0];
                fsct_pkg::REG_SLOPE_V: r_sv   <= i_cfg_data[fsct_pkg::SLOPE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: global enable
    logic [DEPTH-1:0] r_vld;
    logic             w_en;
    assign w_en          = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
    end

    logic [INW-1:0] w_in;
    assign w_in = s_axis_tdata;

    // stage 1: offsets and half-extent squares
    logic signed [OW-1:0] r_o [3];
    logic [QW-1:0] r_hsq [3];
    logic [fsct_pkg::FLAG_WIDTH-1:0] r_fl1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_o[i] <= OW'($signed(w_in[i*CW +: CW]))
                        - OW'($signed(r_cam[i*CW +: CW]));
                r_hsq[i] <= QW'(w_in[3*CW+i*HW +: HW]) * QW'(w_in[3*CW+i*HW +: HW]);
            end
            r_fl1 <= s_axis_tuser;
        end
    end

    // stage 2: nine products, sum of squares
    logic signed [PW-1:0] r_p [3][3];
    logic [QW-1:0] r_sq;
    logic [fsct_pkg::FLAG_WIDTH-1:0] r_fl2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[0][i] <= PW'(r_o[i]) * PW'($signed(r_fwd[i*AW +: AW]));
                r_p[1][i] <= PW'(r_o[i]) * PW'($signed(r_up[i*AW +: AW]));
                r_p[2][i] <= PW'(r_o[i]) * PW'($signed(r_rgt[i*AW +: AW]));
            end
            r_sq  <= r_hsq[0] + r_hsq[1] + r_hsq[2];
            r_fl2 <= r_fl1;
        end
    end

    // stage 3: projections (arith shift floors)
    logic signed [JW-1:0] r_j [3];
    logic signed [SW-1:0] w_sum [3];
    always_comb begin
        for (int a = 0; a < 3; a++)
            w_sum[a] = SW'(r_p[a][0]) + SW'(r_p[a][1]) + SW'(r_p[a][2]);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) r_j[a] <= JW'(w_sum[a] >>> (AW - 2));
        end
    end

    // r_fl2 lines up with r_j via one extra register
    logic [fsct_pkg::FLAG_WIDTH-1:0] r_fl3;
    logic [QW-1:0] r_sq3;
    always_ff @(posedge i_clk) if (w_en) begin r_fl3 <= r_fl2; r_sq3 <= r_sq; end

    // square root: NSQ stages, one result bit each; projections ride along
    logic [QW-1:0] r_rem  [1:NSQ-1];
    logic [RW-1:0] r_root [1:NSQ];
    logic signed [JW-1:0] r_jd [1:NSQ][3];
    logic [fsct_pkg::FLAG_WIDTH-1:0] r_fld [1:NSQ];

    genvar k;
    generate
        for (k = 0; k < NSQ; k++) begin : g_sqrt
            localparam int B = NSQ - 1 - k;
            logic [QW-1:0] w_rem_in;
            logic [QW-1:0] w_trial;
            logic [RW-1:0] w_root_in;
            logic signed [JW-1:0] w_jd_in [3];
            logic [fsct_pkg::FLAG_WIDTH-1:0] w_fld_in;
            logic w_take;
            if (k == 0) begin : g_first
                assign w_rem_in   = r_sq3;
                assign w_root_in  = '0;
                assign w_jd_in[0] = r_j[0];
                assign w_jd_in[1] = r_j[1];
                assign w_jd_in[2] = r_j[2];
                assign w_fld_in   = r_fl3;
            end else begin : g_next
                assign w_rem_in   = r_rem[k];
                assign w_root_in  = r_root[k];
                assign w_jd_in[0] = r_jd[k][0];
                assign w_jd_in[1] = r_jd[k][1];
                assign w_jd_in[2] = r_jd[k][2];
                assign w_fld_in   = r_fld[k];
            end
            assign w_trial = (QW'(w_root_in) << (B + 1)) | (QW'(1) << (2 * B));
            assign w_take  = (w_rem_in >= w_trial);
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_root[k+1] <= w_take ? (w_root_in | RW'(RW'(1) << B)) : w_root_in;
                    for (int a = 0; a < 3; a++) r_jd[k+1][a] <= w_jd_in[a];
                    r_fld[k+1] <= w_fld_in;
                end
            end
            // the last stage needs no remainder
            if (k < NSQ - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (w_en) r_rem[k+1] <= w_take ? w_rem_in - w_trial : w_rem_in;
                end
            end
        end
    endgenerate

    // lateral limits: slope * f, and scaled terms
    logic signed [LW-1:0] r_limv, r_limh, r_pu, r_pr, r_r20;
    logic signed [JW-1:0] r_f5;
    logic [RW-1:0] r_r5;
    logic [fsct_pkg::FLAG_WIDTH-1:0] r_fl5;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_limv <= LW'(r_jd[NSQ][0]) * LW'($signed({1'b0, r_sv}));
            r_limh <= LW'(r_jd[NSQ][0]) * LW'($signed({1'b0, r_sh}));
            r_pu   <= LW'(r_jd[NSQ][1]) <<< 12;
            r_pr   <= LW'(r_jd[NSQ][2]) <<< 12;
            r_r20  <= LW'($signed({1'b0, r_root[NSQ]})) <<< 12;
            r_f5   <= r_jd[NSQ][0];
            r_r5   <= r_root[NSQ];
            r_fl5  <= r_fld[NSQ];
        end
    end

    // axis classification
    function automatic logic [1:0] side(input logic signed [LW-1:0] p,
                                        input logic signed [LW-1:0] r,
                                        input logic signed [LW-1:0] l);
        logic [1:0] res;
        res = fsct_pkg::AX_PARTIAL;
        if (p < -l - r || l + r < p) res = fsct_pkg::AX_FAIL;
        else if (-l < p - r && p + r < l) res = fsct_pkg::AX_INSIDE;
        return res;
    endfunction

    logic [1:0] r_tf, r_tu, r_tr;
    logic [fsct_pkg::FLAG_WIDTH-1:0] r_fl6;
    logic signed [JW+1:0] w_f, w_r, w_n, w_fa;
    always_comb begin
        w_f  = (JW+2)'(r_f5);
        w_r  = (JW+2)'($signed({1'b0, r_r5}));
        w_n  = (JW+2)'($signed({1'b0, r_near}));
        w_fa = (JW+2)'($signed({1'b0, r_far}));
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_f < w_n - w_r || w_fa + w_r < w_f) r_tf <= fsct_pkg::AX_FAIL;
            else if (w_n < w_f - w_r && w_f + w_r < w_fa) r_tf <= fsct_pkg::AX_INSIDE;
            else r_tf <= fsct_pkg::AX_PARTIAL;
            r_tu  <= side(r_pu, r_r20, r_limv);
            r_tr  <= side(r_pr, r_r20, r_limh);
            r_fl6 <= r_fl5;
        end
    end

    // combine, output register
    logic [fsct_pkg::VERDICT_WIDTH-1:0] n_v, r_v;
    logic [fsct_pkg::FLAG_WIDTH-1:0] n_fo, r_fo;
    logic [1:0] w_t [3];
    always_comb begin
        logic stop;
        stop = 1'b0;
        w_t[0] = r_tf; w_t[1] = r_tu; w_t[2] = r_tr;
        n_v  = fsct_pkg::VERDICT_CONTAIN;
        n_fo = r_fl6;
        for (int a = 0; a < 3; a++) begin
            if (!stop && !r_fl6[a]) begin
                if (w_t[a] == fsct_pkg::AX_FAIL) begin
                    n_v = fsct_pkg::VERDICT_DISJOINT;
                    stop = 1'b1;
                end else if (w_t[a] == fsct_pkg::AX_INSIDE) begin
                    n_fo[a] = 1'b1;
                end else begin
                    n_v = fsct_pkg::VERDICT_INTERSECT;
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin r_v <= n_v; r_fo <= n_fo; end
    end
    assign m_axis_tdata = {3'b000, r_fo, r_v};

    // checks
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_v != 2'd3))
        else $error("bad verdict code");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_v == fsct_pkg::VERDICT_CONTAIN) |-> (r_fo == 3'b111))
        else $error("contain without all flags");
endmodule

// ----- test/frustum_sphere_cull_test_tb.sv -----
`timescale 1ns / 1ps
module frustum_sphere_cull_test_tb;
    localparam int CW   = 20;
    localparam int AW   = 16;
    localparam int HW   = fsct_pkg::HALF_WIDTH;
    localparam int FW   = fsct_pkg::FLAG_WIDTH;
    localparam int DW   = fsct_pkg::DIST_WIDTH;
    localparam int SLW  = fsct_pkg::SLOPE_WIDTH;
    localparam int IXW  = fsct_pkg::CFG_IDX_WIDTH;
    localparam int TD_W = ((3*CW + 3*HW + 7) / 8) * 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [IXW-1:0] i_cfg_index = '0;
    logic [fsct_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TD_W-1:0] s_axis_tdata = '0;
    logic [FW-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    frustum_sphere_cull_test #(.COORD_WIDTH(CW), .AXIS_WIDTH(AW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the frustum registers
    logic [3*CW-1:0] cam_pos = '0;
    logic [3*AW-1:0] fwd_ax = '0, up_ax = '0, right_ax = '0;
    logic [DW-1:0] near_d = '0, far_d = '0;
    logic [SLW-1:0] slope_h = fsct_pkg::SLOPE_RESET, slope_v = fsct_pkg::SLOPE_RESET;

    logic [4:0] verdict_q[$];   // {flags_out, verdict}
    int errors = 0;
    int boxes_sent = 0;
    int verdicts_seen = 0;
    int verdict_hist[3] = '{0, 0, 0};
    bit idle_on = 1'b1;

    function automatic longint sx_coord(logic [CW-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sx_axis(logic [AW-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint dot_q8(longint ox, longint oy, longint oz,
                                      logic [3*AW-1:0] ax);
        longint s;
        s = ox * sx_axis(ax[AW-1:0]) + oy * sx_axis(ax[2*AW-1:AW])
            + oz * sx_axis(ax[3*AW-1:2*AW]);
        return s >>> (AW - 2);
    endfunction

    function automatic logic [1:0] lateral(longint p, longint r, longint f,
                                           logic [SLW-1:0] slope);
        longint lim, p20, r20;
        lim = longint'(slope) * f;
        p20 = p * 4096;
        r20 = r * 4096;
        if (p20 < -lim - r20 || lim + r20 < p20) return fsct_pkg::AX_FAIL;
        if (-lim < p20 - r20 && p20 + r20 < lim) return fsct_pkg::AX_INSIDE;
        return fsct_pkg::AX_PARTIAL;
    endfunction

    function automatic logic [4:0] predict_cull(logic [TD_W-1:0] d, logic [FW-1:0] fl);
        longint ox, oy, oz, r, f;
        longint unsigned hx, hy, hz;
        logic [1:0] t;
        logic [fsct_pkg::VERDICT_WIDTH-1:0] v;
        ox = sx_coord(d[CW-1:0]) - sx_coord(cam_pos[CW-1:0]);
        oy = sx_coord(d[2*CW-1:CW]) - sx_coord(cam_pos[2*CW-1:CW]);
        oz = sx_coord(d[3*CW-1:2*CW]) - sx_coord(cam_pos[3*CW-1:2*CW]);
        hx = d[3*CW +: HW];
        hy = d[3*CW+HW +: HW];
        hz = d[3*CW+2*HW +: HW];
        r = longint'(int_sqrt(hx*hx + hy*hy + hz*hz));
        f = dot_q8(ox, oy, oz, fwd_ax);
        v = fsct_pkg::VERDICT_CONTAIN;
        if (!fl[0]) begin
            if (f < longint'(near_d) - r || longint'(far_d) + r < f)
                return {fl, fsct_pkg::VERDICT_DISJOINT};
            if (longint'(near_d) < f - r && f + r < longint'(far_d)) fl[0] = 1'b1;
            else v = fsct_pkg::VERDICT_INTERSECT;
        end
        if (!fl[1]) begin
            t = lateral(dot_q8(ox, oy, oz, up_ax), r, f, slope_v);
            if (t == fsct_pkg::AX_FAIL) return {fl, fsct_pkg::VERDICT_DISJOINT};
            if (t == fsct_pkg::AX_INSIDE) fl[1] = 1'b1;
            else v = fsct_pkg::VERDICT_INTERSECT;
        end
        if (!fl[2]) begin
            t = lateral(dot_q8(ox, oy, oz, right_ax), r, f, slope_h);
            if (t == fsct_pkg::AX_FAIL) return {fl, fsct_pkg::VERDICT_DISJOINT};
            if (t == fsct_pkg::AX_INSIDE) fl[2] = 1'b1;
            else v = fsct_pkg::VERDICT_INTERSECT;
        end
        return {fl, v};
    endfunction

    task automatic report_mismatch(string what, logic [4:0] got, logic [4:0] exp_v);
        errors++;
        $display("MISMATCH %s: got verdict %0d flags %b, want verdict %0d flags %b",
                 what, got[1:0], got[4:2], exp_v[1:0], exp_v[4:2]);
    endtask

    // result side: random stalls, checking
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!idle_on || !i_rst_n) begin
            m_axis_tready <= i_rst_n;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata[4:0], 5'd0);
            end else begin
                logic [4:0] e;
                e = verdict_q.pop_front();
                if (m_axis_tdata[4:0] !== e || m_axis_tdata[7:5] !== 3'b0)
                    report_mismatch("verdict/flags", m_axis_tdata[4:0], e);
                if (e[1:0] <= fsct_pkg::VERDICT_CONTAIN) verdict_hist[e[1:0]]++;
            end
        end
    end

    task automatic write_reg(logic [IXW-1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            fsct_pkg::REG_CAMERA:  cam_pos = val[3*CW-1:0];
            fsct_pkg::REG_FORWARD: fwd_ax = val[3*AW-1:0];
            fsct_pkg::REG_UP:      up_ax = val[3*AW-1:0];
            fsct_pkg::REG_RIGHT:   right_ax = val[3*AW-1:0];
            fsct_pkg::REG_NEAR:    near_d = val[DW-1:0];
            fsct_pkg::REG_FAR:     far_d = val[DW-1:0];
            fsct_pkg::REG_SLOPE_H: slope_h = val[SLW-1:0];
            default:               slope_v = val[SLW-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_frustum(logic [3*CW-1:0] cam, logic [3*AW-1:0] fw,
                               logic [3*AW-1:0] up, logic [3*AW-1:0] rt,
                               logic [DW-1:0] nd, logic [DW-1:0] fd,
                               logic [SLW-1:0] sh, logic [SLW-1:0] sv);
        write_reg(fsct_pkg::REG_CAMERA, 64'(cam));
        write_reg(fsct_pkg::REG_FORWARD, 64'(fw));
        write_reg(fsct_pkg::REG_UP, 64'(up));
        write_reg(fsct_pkg::REG_RIGHT, 64'(rt));
        write_reg(fsct_pkg::REG_NEAR, 64'(nd));
        write_reg(fsct_pkg::REG_FAR, 64'(fd));
        write_reg(fsct_pkg::REG_SLOPE_H, 64'(sh));
        write_reg(fsct_pkg::REG_SLOPE_V, 64'(sv));
    endtask

    task automatic send_box(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                            logic [HW-1:0] hx, logic [HW-1:0] hy,
                            logic [HW-1:0] hz, logic [FW-1:0] fl);
        logic [TD_W-1:0] d;
        int gap;
        d = {3'b0, hz, hy, hx, cz, cy, cx};
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= fl;
        do @(posedge i_clk); while (!s_axis_tready);
        verdict_q.push_back(predict_cull(d, fl));
        boxes_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    localparam logic [3*AW-1:0] AX_Z = {16'sd16384, 16'sd0, 16'sd0};
    localparam logic [3*AW-1:0] AX_Y = {16'sd0, 16'sd16384, 16'sd0};
    localparam logic [3*AW-1:0] AX_X = {16'sd0, 16'sd0, 16'sd16384};

    task automatic test_directed;
        // camera at origin looking down +z, near 1.0, far 100.0, 90 deg fov
        set_frustum('0, AX_Z, AX_Y, AX_X, 19'd256, 19'd25600, 16'd4096, 16'd4096);
        send_box('0, '0, 20'd2560, 19'd128, 19'd128, 19'd128, 3'b000);    // contain
        send_box('0, '0, 20'd128, 19'd256, 19'd0, 19'd0, 3'b000);         // near straddle
        send_box('0, '0, -20'sd5000, 19'd10, 19'd10, 19'd10, 3'b000);     // behind
        send_box('0, '0, 20'd40000, 19'd10, 19'd10, 19'd10, 3'b000);      // past far
        send_box('0, 20'd9000, 20'd2560, 19'd10, 19'd10, 19'd10, 3'b000); // above
        send_box(20'd9000, '0, 20'd2560, 19'd10, 19'd10, 19'd10, 3'b000); // right of view
        send_box('0, 20'd2560, 20'd2560, 19'd64, '0, '0, 3'b000);         // up edge
        send_box(20'd2560, '0, 20'd2560, 19'd64, '0, '0, 3'b000);         // right edge
        // forward newly contained, then up fails: flags keep forward bit
        send_box('0, 20'd9000, 20'd2560, 19'd10, 19'd10, 19'd10, 3'b100);
        for (int k = 0; k < 8; k++)
            send_box(20'd9000, 20'd9000, -20'sd9000, 19'd5, 19'd5, 19'd5, 3'(k));
        send_box(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 3'b111);
        send_box(20'h80000, 20'h80000, 20'h80000, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 3'b000);
        send_box('0, '0, '0, '0, '0, '0, 3'b000);
        drain();
        // zero axes: every projection is zero
        set_frustum('0, '0, '0, '0, 19'd0, 19'd10, 16'd0, 16'd0);
        send_box(20'd100, 20'd100, 20'd100, '0, '0, '0, 3'b000);
        send_box(20'd100, 20'd100, 20'd100, 19'd1, '0, '0, 3'b000);
        drain();
    endtask

    // boxes near the view, mixed with fully random ones, on axis-aligned or random frusta
    task automatic test_random_scene(int n, bit aligned);
        logic [CW-1:0] cam_c[3];
        int fd, spread;
        for (int k = 0; k < 3; k++) cam_c[k] = CW'($urandom_range(0, 40000) - 20000);
        if (aligned)
            set_frustum({cam_c[2], cam_c[1], cam_c[0]}, AX_Z, AX_Y, AX_X,
                        19'($urandom_range(0, 2000)), 19'($urandom_range(3000, 60000)),
                        16'($urandom_range(1000, 12000)), 16'($urandom_range(1000, 12000)));
        else
            set_frustum({cam_c[2], cam_c[1], cam_c[0]}, 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        19'($urandom), 19'($urandom), 16'($urandom), 16'($urandom));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_box(CW'($urandom), CW'($urandom), CW'($urandom),
                         19'($urandom), 19'($urandom), 19'($urandom), 3'($urandom));
            end else begin
                fd = $urandom_range(0, int'(far_d) + 4000) - 1000;
                spread = (fd < 0 ? 500 : fd) + 2000;
                send_box(CW'(int'($signed(cam_c[0])) + $urandom_range(0, 2*spread) - spread),
                         CW'(int'($signed(cam_c[1])) + $urandom_range(0, 2*spread) - spread),
                         CW'(int'($signed(cam_c[2])) + fd),
                         19'($urandom_range(0, 1500)), 19'($urandom_range(0, 1500)),
                         19'($urandom_range(0, 1500)), 3'($urandom_range(0, 7)));
            end
        end
        drain();
    endtask

    task automatic test_extreme_regs;
        set_frustum({60{1'b1}}, {48{1'b1}}, {3{16'h7FFF}}, {3{16'h8000}},
                    19'h7FFFF, 19'h7FFFF, 16'hFFFF, 16'hFFFF);
        repeat (40)
            send_box(CW'($urandom), CW'($urandom), CW'($urandom),
                     19'($urandom), 19'($urandom), 19'($urandom), 3'($urandom));
        drain();
        set_frustum({3{20'h7FFFF}}, {3{16'h8000}}, {3{16'h7FFF}}, {48{1'b1}},
                    19'd0, 19'h7FFFF, 16'd0, 16'hFFFF);
        repeat (40)
            send_box(CW'($urandom), CW'($urandom), CW'($urandom),
                     19'($urandom), 19'($urandom), 19'($urandom), 3'($urandom));
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extreme_regs();
        test_random_scene(300, 1'b1);
        test_random_scene(250, 1'b1);
        test_random_scene(250, 1'b0);
        test_random_scene(250, 1'b1);
        test_random_scene(200, 1'b0);
        idle_on = 1'b0;
        test_random_scene(200, 1'b1);
        repeat (40) @(posedge i_clk);
        $display("covered %0d boxes over directed, extreme and random frusta", boxes_sent);
        $display("verdicts checked: %0d disjoint, %0d intersect, %0d contain",
                 verdict_hist[0], verdict_hist[1], verdict_hist[2]);
        if (errors == 0 && verdict_q.size() == 0)
            $display("frustum_sphere_cull_test regression: pass");
        else
            $display("frustum_sphere_cull_test regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("frustum_sphere_cull_test regression: fail");
        $finish;
    end
endmodule
